FILE: sv/bb_pkg.sv
// shared types, constants and the divide-by-count reciprocal table for the box blur
package bb_pkg;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    // arithmetic widths
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = 13;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef logic [23:0] pixel_t;

    // one window snapshot with the in-frame masks of its one or two results
    typedef struct packed {
        pixel_t [8:0] px;
        logic   [8:0] mask1;
        logic   [8:0] mask2;
        logic         emit1;
        logic         emit2;
        logic         frame_last;
    } job_t;

    // ceil(2^18 / (2*cnt)), exact for numerators below 4600
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/bb_front.sv
// front end: position counters, line stores, 3x3 window and job building
module bb_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  logic [bb_pkg::QCW-1:0] q_count,
    output logic                 push,
    output bb_pkg::job_t         push_job
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [10:0]   width_reg;
    logic [15:0]   height_reg;
    logic [XW-1:0] col_reg;
    logic [16:0]   row_reg;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [XW-1:0] x_a;
    logic          drain;
    logic          last_col;
    logic          accept;
    logic          take;
    bb_pkg::pixel_t pix_a;
    logic [bb_pkg::QCW:0] occ;

    // stage b registers
    logic           b_valid_reg;
    logic [XW-1:0]  b_x_reg;
    bb_pkg::pixel_t b_pix_reg;
    logic           b_emit1_reg;
    logic           b_emit2_reg;
    logic           b_rv0_reg;
    logic           b_rv2_reg;
    logic           b_c0_reg;
    logic           b_c1_reg;
    logic           b_fend_reg;
    logic           fwd_reg;
    bb_pkg::pixel_t up_rd_reg;
    bb_pkg::pixel_t lo_rd_reg;
    bb_pkg::pixel_t last_lo_reg;
    bb_pkg::pixel_t up_b;

    bb_pkg::pixel_t upper_mem [MAX_WIDTH];
    bb_pkg::pixel_t lower_mem [MAX_WIDTH];

    bb_pkg::pixel_t [2:0][2:0] win_reg;
    bb_pkg::pixel_t [2:0][2:0] win_next;

    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
    end

    assign h_eff    = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign x_a      = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
    assign drain    = (row_reg >= {1'b0, h_eff});
    assign last_col = (WW'(x_a) == (w_eff - WW'(1)));
    assign pix_a    = drain ? '0 : {red_in, green_in, blue_in};

    assign push = b_valid_reg && (b_emit1_reg || b_emit2_reg);
    assign occ  = {1'b0, q_count} + {{bb_pkg::QCW{1'b0}}, push};

    // room for the job in stage b and the one entering now
    assign in_stall = (occ >= (bb_pkg::QCW + 1)'(bb_pkg::QDEPTH));
    assign accept   = in_valid && !in_stall;
    // a flush before the drain row is swallowed
    assign take     = accept && !((op == bb_pkg::OP_FLUSH) && !drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 11'd1024;
            height_reg  <= 16'd1024;
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= take;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bb_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                    bb_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:                  width_reg  <= width_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (take)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= drain ? 17'd0 : row_reg + 17'd1;
                end
                else
                begin
                    col_reg <= x_a + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b_x_reg     <= x_a;
            b_pix_reg   <= pix_a;
            b_emit1_reg <= (row_reg != 17'd0) && (x_a != '0);
            b_emit2_reg <= (row_reg != 17'd0) && last_col;
            b_rv0_reg   <= (row_reg >= 17'd2);
            b_rv2_reg   <= !drain;
            b_c0_reg    <= (x_a >= XW'(2));
            b_c1_reg    <= (x_a != '0);
            b_fend_reg  <= drain;
            fwd_reg     <= b_valid_reg && (b_x_reg == x_a);
        end
    end

    // lower store: row y-1, read before write at the same column
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lo_rd_reg     <= lower_mem[x_a];
            lower_mem[x_a] <= pix_a;
        end
    end

    // upper store: row y-2, refilled from the lower read on the next cycle
    always_ff @(posedge clk)
    begin
        if (take)
            up_rd_reg <= upper_mem[x_a];
        if (b_valid_reg)
            upper_mem[b_x_reg] <= lo_rd_reg;
    end

    // same column back to back: take the value being written this cycle
    assign up_b = fwd_reg ? last_lo_reg : up_rd_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_b;
        win_next[1][2] = lo_rd_reg;
        win_next[2][2] = b_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            win_reg     <= win_next;
            last_lo_reg <= lo_rd_reg;
        end
    end

    always_comb
    begin
        logic rowv;
        logic col1;
        logic col2;
        push_job = '0;
        for (int r = 0; r < 3; r++)
        begin
            rowv = (r == 0) ? b_rv0_reg : ((r == 1) ? 1'b1 : b_rv2_reg);
            for (int k = 0; k < 3; k++)
            begin
                col1 = (k == 0) ? b_c0_reg : 1'b1;
                col2 = (k == 0) ? 1'b0 : ((k == 1) ? b_c1_reg : 1'b1);
                push_job.px[r * 3 + k]    = win_next[r][k];
                push_job.mask1[r * 3 + k] = rowv && col1;
                push_job.mask2[r * 3 + k] = rowv && col2;
            end
        end
        push_job.emit1      = b_emit1_reg;
        push_job.emit2      = b_emit2_reg;
        push_job.frame_last = b_fend_reg;
    end

endmodule

FILE: sv/bb_queue.sv
// small job queue between the front and back ends
module bb_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bb_pkg::job_t           push_job,
    input  logic                   pop,
    output bb_pkg::job_t           head_job,
    output logic [bb_pkg::QCW-1:0] count
);

    bb_pkg::job_t            mem_reg [bb_pkg::QDEPTH];
    logic [bb_pkg::QPW-1:0]  wr_ptr_reg;
    logic [bb_pkg::QPW-1:0]  rd_ptr_reg;
    logic [bb_pkg::QCW-1:0]  count_reg;

    assign head_job = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bb_pkg::QPW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bb_pkg::QPW'(1);
            if (push && !pop)
                count_reg <= count_reg + bb_pkg::QCW'(1);
            else if (pop && !push)
                count_reg <= count_reg - bb_pkg::QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: sv/bb_back.sv
// back end: masked window sums, rounded divide by count, output register
module bb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bb_pkg::job_t           head_job,
    input  logic [bb_pkg::QCW-1:0] q_count,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             red_out,
    output logic [7:0]             green_out,
    output logic [7:0]             blue_out,
    output logic                   row_end,
    output logic                   frame_end,
    output logic                   run_last
);

    logic       phase_reg;
    logic       adv;
    logic       first_sel;
    logic       last;
    logic       issue;
    logic [8:0] mask;

    logic [bb_pkg::SUM_W-1:0] sum_r;
    logic [bb_pkg::SUM_W-1:0] sum_g;
    logic [bb_pkg::SUM_W-1:0] sum_b;
    logic [bb_pkg::CNT_W-1:0] cnt;

    logic                     s1_valid_reg;
    logic [bb_pkg::SUM_W-1:0] s1_sum_r_reg;
    logic [bb_pkg::SUM_W-1:0] s1_sum_g_reg;
    logic [bb_pkg::SUM_W-1:0] s1_sum_b_reg;
    logic [bb_pkg::CNT_W-1:0] s1_cnt_reg;
    logic                     s1_row_end_reg;
    logic                     s1_frame_end_reg;
    logic                     s1_last_reg;

    logic [bb_pkg::RECIP_W-1:0] rcp;
    logic [bb_pkg::NUM_W-1:0]   num_r;
    logic [bb_pkg::NUM_W-1:0]   num_g;
    logic [bb_pkg::NUM_W-1:0]   num_b;
    logic [bb_pkg::PROD_W-1:0]  prod_r;
    logic [bb_pkg::PROD_W-1:0]  prod_g;
    logic [bb_pkg::PROD_W-1:0]  prod_b;

    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       row_end_reg;
    logic       frame_end_reg;
    logic       run_last_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign first_sel = !phase_reg && head_job.emit1;
    assign mask      = first_sel ? head_job.mask1 : head_job.mask2;
    assign last      = !first_sel || !head_job.emit2;
    assign issue     = (q_count != '0) && adv;
    assign pop       = issue && last;

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (mask[i])
            begin
                sum_r = sum_r + bb_pkg::SUM_W'(head_job.px[i][23:16]);
                sum_g = sum_g + bb_pkg::SUM_W'(head_job.px[i][15:8]);
                sum_b = sum_b + bb_pkg::SUM_W'(head_job.px[i][7:0]);
            end
        end
        cnt = bb_pkg::CNT_W'($countones(mask));
    end

    // (2*sum + cnt) / (2*cnt) as a reciprocal multiply
    assign rcp    = bb_pkg::recip(s1_cnt_reg);
    assign num_r  = {s1_sum_r_reg, 1'b0} + bb_pkg::NUM_W'(s1_cnt_reg);
    assign num_g  = {s1_sum_g_reg, 1'b0} + bb_pkg::NUM_W'(s1_cnt_reg);
    assign num_b  = {s1_sum_b_reg, 1'b0} + bb_pkg::NUM_W'(s1_cnt_reg);
    assign prod_r = bb_pkg::PROD_W'(num_r) * bb_pkg::PROD_W'(rcp);
    assign prod_g = bb_pkg::PROD_W'(num_g) * bb_pkg::PROD_W'(rcp);
    assign prod_b = bb_pkg::PROD_W'(num_b) * bb_pkg::PROD_W'(rcp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                phase_reg <= !last;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_sum_r_reg     <= sum_r;
            s1_sum_g_reg     <= sum_g;
            s1_sum_b_reg     <= sum_b;
            s1_cnt_reg       <= cnt;
            s1_row_end_reg   <= !first_sel;
            s1_frame_end_reg <= !first_sel && head_job.frame_last;
            s1_last_reg      <= last;
        end
        if (adv && s1_valid_reg)
        begin
            red_reg       <= prod_r[bb_pkg::RECIP_SHIFT +: 8];
            green_reg     <= prod_g[bb_pkg::RECIP_SHIFT +: 8];
            blue_reg      <= prod_b[bb_pkg::RECIP_SHIFT +: 8];
            row_end_reg   <= s1_row_end_reg;
            frame_end_reg <= s1_frame_end_reg;
            run_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

endmodule

FILE: sv/box_blur_3x3_rgb.sv
// top level of the 3x3 rgb box blur: front end, job queue and back end
//
// usage:
//   input channel (in_valid / in_stall): one word per pixel in raster order,
//   op selects pixel or flush; after the last row send frame_width flush words
//   to drain it. output channel (out_valid / out_stall): one blurred pixel per
//   word, row y-1 comes out one column behind row y.
//   configuration: cfg_write with cfg_index 0 (frame_width) or 1 (frame_height)
//   and cfg_data; any write restarts the frame. write only while idle.
// path: an accepted word goes through the line store read, the window stage,
//   the sum stage and the divide to its first result.
// throughput: one word per cycle while in_stall is low; the last word of a row
//   gives two results, issued by the back end one after the other, and the
//   4-entry job queue absorbs this; a row of w words gives w results.
// reset: frame position cleared, frame_width and frame_height set to 1024,
//   queue and pipeline emptied. line stores are not cleared; never-written
//   entries only ever land outside the frame.
// stall: out_stall freezes the back end and its output word; the front keeps
//   taking words until the queue is full, then raises in_stall.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        row_end,
    output logic        frame_end,
    output logic        run_last
);

    // job handoff front -> queue -> back
    logic                   push;
    bb_pkg::job_t           push_job;
    logic                   pop;
    bb_pkg::job_t           head_job;
    logic [bb_pkg::QCW-1:0] q_count;

    // position tracking, line stores and window
    bb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .q_count   (q_count),
        .push      (push),
        .push_job  (push_job)
    );

    // decouples the front from output stalls
    bb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .count    (q_count)
    );

    // averaging and output register
    bb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_count   (q_count),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule
